### hdl/mrb_pkg.sv
// Shared types, codes and reset values of the multicast ring buffer.
`default_nettype none
package mrb_pkg;

    localparam int DEF_RING_DEPTH  = 64;
    localparam int DEF_MAX_READERS = 16;
    localparam int DEF_WORD_BITS   = 32;

    localparam int OP_W     = 3;
    localparam int RID_W    = 4;
    localparam int LEN_W    = 16;
    localparam int STAT_W   = 3;
    localparam int SIZE_W   = 7;
    localparam int TMO_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 32;

    localparam logic [SIZE_W-1:0] RST_RING_SIZE = 7'd64;
    localparam logic [LEN_W-1:0]  RST_MAX_LEN   = 16'd1024;
    localparam logic [TMO_W-1:0]  RST_TIMEOUT   = 32'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

    localparam logic [OP_W-1:0] OP_OPEN  = 3'd0;
    localparam logic [OP_W-1:0] OP_CLOSE = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
    localparam logic [OP_W-1:0] OP_READ  = 3'd3;
    localparam logic [OP_W-1:0] OP_POLL  = 3'd4;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_BLOCK     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOFREE    = 3'd2;
    localparam logic [STAT_W-1:0] ST_OFFLINE   = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADLEN    = 3'd4;
    localparam logic [STAT_W-1:0] ST_BADREADER = 3'd5;

    // Classified command passed from the front end to the executor.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [RID_W-1:0] rid;
        logic             rid_ok;
        logic             len_ok;
        logic [LEN_W-1:0] msg_len;
        logic [LEN_W-1:0] req_len;
    } t_cmd;

    // Queue status seen by the executor and the top level.
    typedef struct packed {
        logic       empty;
        logic       full;
        logic [1:0] count;
    } t_q_stat;

endpackage
`default_nettype wire

### hdl/mrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

### hdl/mrb_front.sv
// Front end: unpack and classify incoming transactions into a two-entry queue.
`default_nettype none
module mrb_front #(
    parameter int WORD_BITS = mrb_pkg::DEF_WORD_BITS,
    parameter int MAX_READERS = mrb_pkg::DEF_MAX_READERS,
    parameter int IN_W = 72
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output      logic                        o_ready,
    input  wire logic [IN_W-1:0]             i_data,
    input  wire logic [mrb_pkg::LEN_W-1:0]   i_max_len,
    input  wire logic                        i_pop,
    output      mrb_pkg::t_cmd               o_cmd,
    output      logic [WORD_BITS-1:0]        o_word,
    output      mrb_pkg::t_q_stat            o_stat
);
    localparam int RID_LO  = mrb_pkg::OP_W;
    localparam int WORD_LO = RID_LO + mrb_pkg::RID_W;
    localparam int MLEN_LO = WORD_LO + WORD_BITS;
    localparam int RLEN_LO = MLEN_LO + mrb_pkg::LEN_W;

    mrb_pkg::t_cmd        r_cmd  [2];
    logic [WORD_BITS-1:0] r_word [2];
    logic                 r_wp, r_rp;
    logic [1:0]           r_cnt;
    mrb_pkg::t_cmd        w_cmd;
    logic                 w_push;

    // Classify: reader range and write length checks.
    always_comb begin
        w_cmd.op      = i_data[mrb_pkg::OP_W-1:0];
        w_cmd.rid     = i_data[RID_LO +: mrb_pkg::RID_W];
        w_cmd.rid_ok  = (32'(w_cmd.rid) < 32'(MAX_READERS));
        w_cmd.msg_len = i_data[MLEN_LO +: mrb_pkg::LEN_W];
        w_cmd.req_len = i_data[RLEN_LO +: mrb_pkg::LEN_W];
        w_cmd.len_ok  = (w_cmd.msg_len != '0) && (w_cmd.msg_len <= i_max_len);
    end

    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_cmd[r_wp]  <= w_cmd;
            r_word[r_wp] <= i_data[WORD_LO +: WORD_BITS];
        end
    end

    assign o_cmd        = r_cmd[r_rp];
    assign o_word       = r_word[r_rp];
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.count = r_cnt;
endmodule
`default_nettype wire

### hdl/mrb_back.sv
// Executor: carries out queued commands against the slot memories.
`default_nettype none
module mrb_back #(
    parameter int RING_DEPTH  = mrb_pkg::DEF_RING_DEPTH,
    parameter int MAX_READERS = mrb_pkg::DEF_MAX_READERS,
    parameter int WORD_BITS   = mrb_pkg::DEF_WORD_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mrb_pkg::t_cmd              i_cmd,
    input  wire logic [WORD_BITS-1:0]       i_word,
    input  wire mrb_pkg::t_q_stat           i_stat,
    output      logic                       o_pop,
    input  wire logic [mrb_pkg::SIZE_W-1:0] i_ring_size,
    input  wire logic [mrb_pkg::TMO_W-1:0]  i_timeout,
    output      logic                       o_valid,
    input  wire logic                       i_ready,
    output      logic [mrb_pkg::STAT_W-1:0] o_status,
    output      logic [mrb_pkg::RID_W-1:0]  o_assigned,
    output      logic [WORD_BITS-1:0]       o_word,
    output      logic [mrb_pkg::LEN_W-1:0]  o_len,
    output      logic                       o_readable,
    output      logic                       o_hangup
);
    localparam int PW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RIW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int CW  = ((PW + 1) > mrb_pkg::SIZE_W) ? (PW + 2) : (mrb_pkg::SIZE_W + 1);
    localparam int DW  = WORD_BITS + mrb_pkg::LEN_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_SW_RD = 5'b01000,
        S_SW_WR = 5'b10000
    } t_state;

    t_state                  r_state, n_state;
    mrb_pkg::t_cmd           r_cmd;
    logic [WORD_BITS-1:0]    r_wdin;
    logic [MAX_READERS-1:0]  r_mask, n_mask;
    logic [MAX_READERS-1:0]  r_online, n_online;
    logic [PW-1:0]           r_rpos [MAX_READERS];
    logic [PW-1:0]           r_wpos, n_wpos;
    logic [RING_DEPTH-1:0]   r_pvld, n_pvld;
    logic [mrb_pkg::TMO_W-1:0] r_wait, n_wait;
    logic                    r_blocked, n_blocked;
    logic [MAX_READERS-1:0]  r_bits, n_bits;
    logic [PW-1:0]           r_addr, n_addr;
    logic [PW-1:0]           r_cnt, n_cnt;

    logic                    r_ovld, n_ovld;
    logic [mrb_pkg::STAT_W-1:0] r_status, n_status;
    logic [mrb_pkg::RID_W-1:0]  r_assigned, n_assigned;
    logic [WORD_BITS-1:0]    r_oword, n_oword;
    logic [mrb_pkg::LEN_W-1:0]  r_olen, n_olen;
    logic                    r_ord, n_ord, r_ohup, n_ohup;

    logic                    w_rpos_we;
    logic [RIW-1:0]          w_rpos_idx;
    logic [PW-1:0]           w_rpos_val;

    logic                    w_pend_we, w_data_we;
    logic [PW-1:0]           w_waddr;
    logic [MAX_READERS-1:0]  w_pend_wdata, w_pend_rdata, w_pend;
    logic [DW-1:0]           w_data_rdata;
    logic [CW-1:0]           w_eff;
    logic [RIW-1:0]          w_rix;
    logic [MAX_READERS-1:0]  w_rbit;
    logic [mrb_pkg::TMO_W-1:0] w_wait_inc;
    logic                    w_found;
    logic [RIW-1:0]          w_free;
    logic [mrb_pkg::LEN_W-1:0] w_slen;

    mrb_ram #(.WIDTH(MAX_READERS), .DEPTH(RING_DEPTH)) u_pend (
        .i_clk(i_clk), .i_we(w_pend_we), .i_waddr(w_waddr), .i_wdata(w_pend_wdata),
        .i_raddr(n_addr), .o_rdata(w_pend_rdata)
    );

    mrb_ram #(.WIDTH(DW), .DEPTH(RING_DEPTH)) u_data (
        .i_clk(i_clk), .i_we(w_data_we), .i_waddr(w_waddr),
        .i_wdata({r_cmd.msg_len, r_wdin}), .i_raddr(n_addr), .o_rdata(w_data_rdata)
    );

    function automatic logic [PW-1:0] f_adv(input logic [PW-1:0] p, input logic [CW-1:0] eff);
        logic [CW-1:0] n;
        n = CW'(p) + CW'(1);
        return (n >= eff) ? '0 : PW'(n);
    endfunction

    always_comb begin
        if (i_ring_size == '0) begin
            w_eff = CW'(1);
        end else if (CW'(i_ring_size) > CW'(RING_DEPTH)) begin
            w_eff = CW'(RING_DEPTH);
        end else begin
            w_eff = CW'(i_ring_size);
        end
    end

    assign w_rix      = RIW'(r_cmd.rid);
    assign w_rbit     = MAX_READERS'(1) << w_rix;
    assign w_pend     = r_pvld[r_addr] ? w_pend_rdata : '0;
    assign w_slen     = w_data_rdata[WORD_BITS +: mrb_pkg::LEN_W];
    assign w_wait_inc = (r_wait == '1) ? r_wait : r_wait + 1'b1;

    // First free reader slot.
    always_comb begin
        w_found = 1'b0;
        w_free  = '0;
        for (int i = 0; i < MAX_READERS; i++) begin
            if (!w_found && !r_mask[i]) begin
                w_found = 1'b1;
                w_free  = RIW'(i);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_mask     = r_mask;
        n_online   = r_online;
        n_wpos     = r_wpos;
        n_pvld     = r_pvld;
        n_wait     = r_wait;
        n_blocked  = r_blocked;
        n_bits     = r_bits;
        n_addr     = r_addr;
        n_cnt      = r_cnt;
        n_ovld     = r_ovld && !i_ready;
        n_status   = r_status;
        n_assigned = r_assigned;
        n_oword    = r_oword;
        n_olen     = r_olen;
        n_ord      = r_ord;
        n_ohup     = r_ohup;
        o_pop      = 1'b0;
        w_rpos_we  = 1'b0;
        w_rpos_idx = w_rix;
        w_rpos_val = '0;
        w_pend_we  = 1'b0;
        w_data_we  = 1'b0;
        w_waddr    = r_addr;
        w_pend_wdata = '0;

        case (r_state)
            S_IDLE: begin
                if (!i_stat.empty && !r_ovld) begin
                    o_pop   = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state    = S_IDLE;
                n_ovld     = 1'b1;
                n_status   = mrb_pkg::ST_OK;
                n_assigned = '0;
                n_oword    = '0;
                n_olen     = '0;
                n_ord      = 1'b0;
                n_ohup     = 1'b0;
                case (r_cmd.op)
                    mrb_pkg::OP_OPEN: begin
                        if (w_found) begin
                            n_mask[w_free]   = 1'b1;
                            n_online[w_free] = 1'b1;
                            w_rpos_we  = 1'b1;
                            w_rpos_idx = w_free;
                            w_rpos_val = r_wpos;
                            n_assigned = mrb_pkg::RID_W'(w_free);
                        end else begin
                            n_status = mrb_pkg::ST_NOFREE;
                        end
                    end
                    mrb_pkg::OP_CLOSE: begin
                        if (!r_cmd.rid_ok) begin
                            n_status = mrb_pkg::ST_BADREADER;
                        end else begin
                            n_ovld  = r_ovld;
                            n_bits  = w_rbit;
                            n_cnt   = '0;
                            n_state = S_SW_RD;
                        end
                    end
                    mrb_pkg::OP_WRITE: begin
                        if (!r_cmd.len_ok) begin
                            n_status = mrb_pkg::ST_BADLEN;
                        end else begin
                            n_ovld  = r_ovld;
                            n_addr  = r_wpos;
                            n_state = S_EVAL;
                        end
                    end
                    mrb_pkg::OP_READ: begin
                        if (!r_cmd.rid_ok) begin
                            n_status = mrb_pkg::ST_BADREADER;
                        end else if (!r_online[w_rix]) begin
                            n_status = mrb_pkg::ST_OFFLINE;
                        end else begin
                            n_ovld  = r_ovld;
                            n_addr  = r_rpos[w_rix];
                            n_state = S_EVAL;
                        end
                    end
                    mrb_pkg::OP_POLL: begin
                        if (!r_cmd.rid_ok) begin
                            n_status = mrb_pkg::ST_BADREADER;
                        end else if (!r_online[w_rix]) begin
                            n_ohup = 1'b1;
                        end else begin
                            n_ovld  = r_ovld;
                            n_addr  = r_rpos[w_rix];
                            n_state = S_EVAL;
                        end
                    end
                    mrb_pkg::OP_TICK: begin
                        if (r_blocked) begin
                            n_wait = w_wait_inc;
                            if (w_wait_inc >= i_timeout) begin
                                n_ovld  = r_ovld;
                                n_addr  = r_wpos;
                                n_state = S_EVAL;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_EVAL: begin
                n_state = S_IDLE;
                n_ovld  = 1'b1;
                case (r_cmd.op)
                    mrb_pkg::OP_WRITE: begin
                        if (w_pend != '0) begin
                            n_status  = mrb_pkg::ST_BLOCK;
                            n_blocked = 1'b1;
                        end else begin
                            w_pend_we    = 1'b1;
                            w_data_we    = 1'b1;
                            w_pend_wdata = r_mask;
                            n_pvld[r_addr] = 1'b1;
                            n_wpos    = f_adv(r_wpos, w_eff);
                            n_blocked = 1'b0;
                            n_wait    = '0;
                        end
                    end
                    mrb_pkg::OP_READ: begin
                        if ((w_pend & w_rbit) == '0) begin
                            n_status = mrb_pkg::ST_BLOCK;
                        end else begin
                            n_oword      = w_data_rdata[WORD_BITS-1:0];
                            n_olen       = (w_slen < r_cmd.req_len) ? w_slen : r_cmd.req_len;
                            w_pend_we    = 1'b1;
                            w_pend_wdata = w_pend & ~w_rbit;
                            w_rpos_we    = 1'b1;
                            w_rpos_val   = f_adv(r_rpos[w_rix], w_eff);
                        end
                    end
                    mrb_pkg::OP_POLL: begin
                        n_ord = ((w_pend & w_rbit) != '0);
                    end
                    default: begin
                        // Timeout: evict the readers pending on the blocking slot.
                        n_ovld    = r_ovld;
                        n_bits    = w_pend;
                        n_blocked = 1'b0;
                        n_wait    = '0;
                        n_cnt     = '0;
                        n_state   = S_SW_RD;
                    end
                endcase
            end
            S_SW_RD: begin
                n_addr  = r_cnt;
                n_state = S_SW_WR;
            end
            S_SW_WR: begin
                w_pend_we    = r_pvld[r_addr];
                w_pend_wdata = w_pend & ~r_bits;
                if (32'(r_cnt) == RING_DEPTH - 1) begin
                    n_mask   = r_mask & ~r_bits;
                    n_online = r_online & ~r_bits;
                    n_ovld   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_SW_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mask    <= '0;
            r_online  <= '0;
            r_wpos    <= '0;
            r_pvld    <= '0;
            r_wait    <= '0;
            r_blocked <= 1'b0;
            r_ovld    <= 1'b0;
            for (int i = 0; i < MAX_READERS; i++) begin
                r_rpos[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_mask    <= n_mask;
            r_online  <= n_online;
            r_wpos    <= n_wpos;
            r_pvld    <= n_pvld;
            r_wait    <= n_wait;
            r_blocked <= n_blocked;
            r_ovld    <= n_ovld;
            if (w_rpos_we) begin
                r_rpos[w_rpos_idx] <= w_rpos_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= i_cmd;
            r_wdin <= i_word;
        end
        r_bits     <= n_bits;
        r_addr     <= n_addr;
        r_cnt      <= n_cnt;
        r_status   <= n_status;
        r_assigned <= n_assigned;
        r_oword    <= n_oword;
        r_olen     <= n_olen;
        r_ord      <= n_ord;
        r_ohup     <= n_ohup;
    end

    assign o_valid    = r_ovld;
    assign o_status   = r_status;
    assign o_assigned = r_assigned;
    assign o_word     = r_oword;
    assign o_len      = r_olen;
    assign o_readable = r_ord;
    assign o_hangup   = r_ohup;
endmodule
`default_nettype wire

### hdl/multicast_ring_buffer.sv
// Top level of the multicast ring buffer: front end, queue, executor and config.
//
// Channel   Dir  Handshake                     Contents
// s_axis    in   s_axis_tvalid/s_axis_tready   one command transaction
// m_axis    out  m_axis_tvalid/m_axis_tready   one result transaction per command
// cfg       in   i_cfg_we                      register write, no read-back
//
// Open, read, write, poll and an idle tick pass from queue head to result through S_EXEC
// and, for read, write and poll, S_EVAL; close and a timing-out tick sweep every slot of
// the pending RAM, with S_SW_RD for the registered read and S_SW_WR for its write-back.
// Reset is synchronous, active low; it clears the slot valid bits at once, so no
// clearing pass is needed. A two-entry queue keeps taking transactions while a
// result waits in the output register; the executor holds while that register is full.
`default_nettype none
module multicast_ring_buffer #(
    parameter int RING_DEPTH  = mrb_pkg::DEF_RING_DEPTH,
    parameter int MAX_READERS = mrb_pkg::DEF_MAX_READERS,
    parameter int WORD_BITS   = mrb_pkg::DEF_WORD_BITS,
    localparam int IN_BITS    = mrb_pkg::OP_W + mrb_pkg::RID_W + WORD_BITS + 2 * mrb_pkg::LEN_W,
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = mrb_pkg::STAT_W + mrb_pkg::RID_W + WORD_BITS + mrb_pkg::LEN_W + 2,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    // opcode, reader_id, msg_word, msg_len, request_len
    input  wire logic [IN_W-1:0]               s_axis_tdata,
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // status, assigned_reader, out_word, out_len, readable, hangup
    output      logic [OUT_W-1:0]              m_axis_tdata,
    input  wire logic                          i_cfg_we,
    input  wire logic [mrb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [mrb_pkg::CFG_W-1:0]     i_cfg_wdata
);
    logic [mrb_pkg::SIZE_W-1:0] r_ring_size;
    logic [mrb_pkg::LEN_W-1:0]  r_max_len;
    logic [mrb_pkg::TMO_W-1:0]  r_timeout;

    mrb_pkg::t_cmd              w_cmd;
    logic [WORD_BITS-1:0]       w_qword;
    mrb_pkg::t_q_stat           w_qstat;
    logic                       w_pop;
    logic [mrb_pkg::STAT_W-1:0] w_status;
    logic [mrb_pkg::RID_W-1:0]  w_assigned;
    logic [WORD_BITS-1:0]       w_oword;
    logic [mrb_pkg::LEN_W-1:0]  w_olen;
    logic                       w_ord, w_ohup;

    // Latch configuration registers; unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= mrb_pkg::RST_RING_SIZE;
            r_max_len   <= mrb_pkg::RST_MAX_LEN;
            r_timeout   <= mrb_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mrb_pkg::CFG_RING_SIZE: r_ring_size <= i_cfg_wdata[mrb_pkg::SIZE_W-1:0];
                mrb_pkg::CFG_MAX_LEN:   r_max_len   <= i_cfg_wdata[mrb_pkg::LEN_W-1:0];
                mrb_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_wdata[mrb_pkg::TMO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mrb_front #(.WORD_BITS(WORD_BITS), .MAX_READERS(MAX_READERS), .IN_W(IN_W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .i_max_len(r_max_len), .i_pop(w_pop),
        .o_cmd(w_cmd), .o_word(w_qword), .o_stat(w_qstat)
    );

    mrb_back #(.RING_DEPTH(RING_DEPTH), .MAX_READERS(MAX_READERS), .WORD_BITS(WORD_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .i_word(w_qword), .i_stat(w_qstat), .o_pop(w_pop),
        .i_ring_size(r_ring_size), .i_timeout(r_timeout),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(w_status), .o_assigned(w_assigned), .o_word(w_oword),
        .o_len(w_olen), .o_readable(w_ord), .o_hangup(w_ohup)
    );

    // Pack result fields, lowest first; pad to whole bytes.
    assign m_axis_tdata = OUT_W'({w_ohup, w_ord, w_olen, w_oword, w_assigned, w_status});

    // Queue never pops while empty.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty) else $error("pop from empty queue");

    // Executor holds while a result is still waiting.
    a_pop_outfree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !m_axis_tvalid) else $error("pop with result pending");

    // An accepted transaction is queued at the next edge.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !w_qstat.empty)
        else $error("accepted transaction lost");

    // Queue fill stays within its two entries.
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.count != 2'd3) else $error("queue overflow");
endmodule
`default_nettype wire
